// ----- sv/sibg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sibg_pkg: shared types and constants of the slab geometry unit
// Widths of coordinates, normal, thickness and internal products, the register
// map and the item structs that travel between the front, queue and back.
// ----------------------------------------------------------------------------
package sibg_pkg;

  // Field widths
  localparam int COORD_W    = 32;
  localparam int NORM_W     = 18;
  localparam int NORM_FRAC  = 16;
  localparam int THICK_W    = 31;
  localparam int DIST_W     = 31;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 4;

  // Internal widths
  localparam int PROD_W   = COORD_W + 1 + NORM_W;   // (point - center) * normal
  localparam int POS_W    = PROD_W + 3;             // 2 * sum of three products
  localparam int SW       = POS_W + 1;              // signed work width
  localparam int ABS_W    = SW;                     // |num|, |den|
  localparam int SQR_W    = 2 * COORD_W;            // one squared component
  localparam int SQ_W     = SQR_W + 2;              // squared length
  localparam int ROOT_W   = SQ_W / 2;               // floor(sqrt) width
  localparam int RREM_W   = ROOT_W + 3;             // root remainder
  localparam int NUMP_W   = ABS_W + ROOT_W;         // |num| * length
  localparam int MSPLIT   = 28;                     // split point of wide factors
  localparam int MW       = SW + NORM_W;            // mirror product width

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 4'd0,
    REG_CENTER_Y = 4'd1,
    REG_CENTER_Z = 4'd2,
    REG_NORMAL_X = 4'd3,
    REG_NORMAL_Y = 4'd4,
    REG_NORMAL_Z = 4'd5,
    REG_THICK    = 4'd6,
    REG_INVERTED = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] center;
    logic [2:0][NORM_W-1:0]  normal;
    logic [THICK_W-1:0]      thick;
    logic                    inv;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] p_x;
    logic signed [COORD_W-1:0] p_y;
    logic signed [COORD_W-1:0] p_z;
    logic signed [COORD_W-1:0] q_x;
    logic signed [COORD_W-1:0] q_y;
    logic signed [COORD_W-1:0] q_z;
  } in_item_t;

  typedef struct packed {
    logic                      p_inside;
    logic                      q_inside;
    logic                      wall_valid;
    logic [DIST_W-1:0]         wall_dist;
    logic                      normal_valid;
    logic [DIST_W-1:0]         normal_dist;
    logic signed [COORD_W-1:0] mirror_x;
    logic signed [COORD_W-1:0] mirror_y;
    logic signed [COORD_W-1:0] mirror_z;
  } out_item_t;

  // Results the front finishes on its own
  typedef struct packed {
    logic                    pin;
    logic                    qin;
    logic                    wv;
    logic [DIST_W-1:0]       nd;
    logic [2:0][COORD_W-1:0] mirror;
  } meta_t;

  // Queue entry: finished results plus the wall distance operands
  typedef struct packed {
    meta_t             meta;
    logic              go;
    logic [ABS_W-1:0]  anum;
    logic [ABS_W-1:0]  aden;
    logic [SQ_W-1:0]   len2;
  } q_ent_t;

endpackage
`default_nettype wire

// ----- sv/sibg_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sibg_cfg: configuration registers
// Holds slab center, normal, thickness and invert flag; drops writes to
// indexes beyond the map and high data bits beyond each register's width.
// ----------------------------------------------------------------------------
module sibg_cfg
  import sibg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center <= '0;
      cfg_r.normal <= {NORM_W'(0), NORM_W'(0), NORM_W'(1 << NORM_FRAC)};
      cfg_r.thick  <= THICK_W'(1 << NORM_FRAC);
      cfg_r.inv    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CENTER_X: cfg_r.center[0] <= cfg_data[COORD_W-1:0];
        REG_CENTER_Y: cfg_r.center[1] <= cfg_data[COORD_W-1:0];
        REG_CENTER_Z: cfg_r.center[2] <= cfg_data[COORD_W-1:0];
        REG_NORMAL_X: cfg_r.normal[0] <= cfg_data[NORM_W-1:0];
        REG_NORMAL_Y: cfg_r.normal[1] <= cfg_data[NORM_W-1:0];
        REG_NORMAL_Z: cfg_r.normal[2] <= cfg_data[NORM_W-1:0];
        REG_THICK:    cfg_r.thick     <= cfg_data[THICK_W-1:0];
        REG_INVERTED: cfg_r.inv       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ----- sv/sibg_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sibg_front: classify a point pair
// Five stages: slab products and squared components, positions and squared
// length, inside tests and wall operands, mirror partial products, mirror.
// ----------------------------------------------------------------------------
module sibg_front
  import sibg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  cfg_t          cfg,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  in_item_t      in_item,
  output logic          push_valid,
  input  wire logic     push_ready,
  output q_ent_t        push_data
);

  logic fadv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  // Stage 1 registers
  logic signed [PROD_W-1:0]  prp_r [3];
  logic signed [PROD_W-1:0]  prq_r [3];
  logic        [SQR_W-1:0]   sqr_r [3];
  logic        [COORD_W-1:0] q1_r  [3];
  // Stage 2 registers
  logic signed [POS_W-1:0]   sp_r, sq_r;
  logic        [SQ_W-1:0]    len2_2_r;
  logic        [COORD_W-1:0] q2_r  [3];
  // Stage 3 registers
  logic                      pin3_r, qin3_r, wv3_r, go3_r;
  logic        [ABS_W-1:0]   anum3_r, aden3_r;
  logic        [SQ_W-1:0]    len2_3_r;
  logic signed [SW-1:0]      w3_r;
  logic        [DIST_W-1:0]  nd3_r;
  logic        [COORD_W-1:0] q3_r  [3];
  // Stage 4 registers
  logic                      pin4_r, qin4_r, wv4_r, go4_r;
  logic        [ABS_W-1:0]   anum4_r, aden4_r;
  logic        [SQ_W-1:0]    len2_4_r;
  logic        [DIST_W-1:0]  nd4_r;
  logic        [COORD_W-1:0] q4_r  [3];
  logic signed [MSPLIT+NORM_W:0]      plo_r [3];
  logic signed [SW-MSPLIT+NORM_W-1:0] phi_r [3];
  // Stage 5 register
  q_ent_t                    ent_r;

  // Advance all stages unless the last one is blocked by a full queue
  assign fadv       = !(v5_r && !push_ready);
  assign in_ready   = fadv;
  assign push_valid = v5_r;
  assign push_data  = ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (fadv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // ---------------- stage 1: products against the normal, squares
  logic signed [COORD_W-1:0] ip_w [3];
  logic signed [COORD_W-1:0] iq_w [3];
  logic signed [COORD_W:0]   dp_w [3];
  logic signed [COORD_W:0]   dq_w [3];
  logic signed [COORD_W:0]   e_w  [3];
  logic        [COORD_W-1:0] ae_w [3];

  assign ip_w[0] = in_item.p_x;
  assign ip_w[1] = in_item.p_y;
  assign ip_w[2] = in_item.p_z;
  assign iq_w[0] = in_item.q_x;
  assign iq_w[1] = in_item.q_y;
  assign iq_w[2] = in_item.q_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dp_w[i] = (COORD_W+1)'(ip_w[i]) - (COORD_W+1)'($signed(cfg.center[i]));
      dq_w[i] = (COORD_W+1)'(iq_w[i]) - (COORD_W+1)'($signed(cfg.center[i]));
      e_w[i]  = (COORD_W+1)'(iq_w[i]) - (COORD_W+1)'(ip_w[i]);
      ae_w[i] = e_w[i][COORD_W] ? COORD_W'(-e_w[i]) : COORD_W'(e_w[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (fadv) begin
      for (int i = 0; i < 3; i++) begin
        prp_r[i] <= PROD_W'(dp_w[i]) * PROD_W'($signed(cfg.normal[i]));
        prq_r[i] <= PROD_W'(dq_w[i]) * PROD_W'($signed(cfg.normal[i]));
        sqr_r[i] <= SQR_W'(ae_w[i]) * SQR_W'(ae_w[i]);
        q1_r[i]  <= iq_w[i];
      end
    end
  end

  // ---------------- stage 2: slab positions and squared length
  always_ff @(posedge clk) begin
    if (fadv) begin
      sp_r     <= (POS_W'(prp_r[0]) + POS_W'(prp_r[1]) + POS_W'(prp_r[2])) <<< 1;
      sq_r     <= (POS_W'(prq_r[0]) + POS_W'(prq_r[1]) + POS_W'(prq_r[2])) <<< 1;
      len2_2_r <= SQ_W'(sqr_r[0]) + SQ_W'(sqr_r[1]) + SQ_W'(sqr_r[2]);
      for (int i = 0; i < 3; i++) begin
        q2_r[i] <= q1_r[i];
      end
    end
  end

  // ---------------- stage 3: inside tests, wall operands, normal distance
  logic signed [SW-1:0] hs_w, spx_w, sqx_w, asp_w, asq_w, ref_w;
  logic signed [SW-1:0] num_w, den_w, w_w, ndv_w, ndr_w;
  logic                 pin_w, qin_w, wv_w, go_w;
  logic [DIST_W-1:0]    nd_w;

  always_comb begin
    hs_w  = SW'({cfg.thick, {NORM_FRAC{1'b0}}});
    spx_w = SW'(sp_r);
    sqx_w = SW'(sq_r);
    asp_w = spx_w[SW-1] ? -spx_w : spx_w;
    asq_w = sqx_w[SW-1] ? -sqx_w : sqx_w;
    pin_w = cfg.inv ? (asp_w > hs_w) : (asp_w < hs_w);
    qin_w = cfg.inv ? (asq_w > hs_w) : (asq_w < hs_w);
    wv_w  = !pin_w && qin_w;
    ref_w = cfg.inv ? sqx_w : spx_w;
    num_w = (ref_w[SW-1] ? -hs_w : hs_w) - spx_w;
    den_w = sqx_w - spx_w;
    go_w  = wv_w && (num_w != '0) && (den_w != '0) && (num_w[SW-1] == den_w[SW-1]);
    w_w   = (sqx_w[SW-1] ? -hs_w : hs_w) - sqx_w;
    // round half up to the input format, then saturate
    ndv_w = cfg.inv ? (asq_w - hs_w) : (hs_w - asq_w);
    ndr_w = (ndv_w + (SW'(1) <<< NORM_FRAC)) >>> (NORM_FRAC + 1);
    if (!qin_w) begin
      nd_w = '0;
    end else if (|ndr_w[SW-1:DIST_W]) begin
      nd_w = '1;
    end else begin
      nd_w = ndr_w[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (fadv) begin
      pin3_r   <= pin_w;
      qin3_r   <= qin_w;
      wv3_r    <= wv_w;
      go3_r    <= go_w;
      anum3_r  <= num_w[SW-1] ? ABS_W'(-num_w) : ABS_W'(num_w);
      aden3_r  <= den_w[SW-1] ? ABS_W'(-den_w) : ABS_W'(den_w);
      len2_3_r <= len2_2_r;
      w3_r     <= w_w;
      nd3_r    <= nd_w;
      for (int i = 0; i < 3; i++) begin
        q3_r[i] <= q2_r[i];
      end
    end
  end

  // ---------------- stage 4: mirror partial products
  logic signed [MSPLIT:0]    wlo_w;
  logic signed [SW-MSPLIT-1:0] whi_w;

  assign wlo_w = $signed({1'b0, w3_r[MSPLIT-1:0]});
  assign whi_w = $signed(w3_r[SW-1:MSPLIT]);

  always_ff @(posedge clk) begin
    if (fadv) begin
      pin4_r   <= pin3_r;
      qin4_r   <= qin3_r;
      wv4_r    <= wv3_r;
      go4_r    <= go3_r;
      anum4_r  <= anum3_r;
      aden4_r  <= aden3_r;
      len2_4_r <= len2_3_r;
      nd4_r    <= nd3_r;
      for (int i = 0; i < 3; i++) begin
        q4_r[i]  <= q3_r[i];
        plo_r[i] <= (MSPLIT+NORM_W+1)'(wlo_w) *
                    (MSPLIT+NORM_W+1)'($signed(cfg.normal[i]));
        phi_r[i] <= (SW-MSPLIT+NORM_W)'(whi_w) *
                    (SW-MSPLIT+NORM_W)'($signed(cfg.normal[i]));
      end
    end
  end

  // ---------------- stage 5: round, add to Q, saturate
  logic signed [MW-1:0]        full_w [3];
  logic signed [MW-1:0]        mr_w   [3];
  logic signed [MW-1:0]        m_w    [3];
  logic        [COORD_W-1:0]   ms_w   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      full_w[i] = (MW'(phi_r[i]) <<< MSPLIT) + MW'(plo_r[i]);
      mr_w[i]   = (full_w[i] + (MW'(1) <<< (2*NORM_FRAC - 1))) >>> (2*NORM_FRAC);
      m_w[i]    = MW'($signed(q4_r[i])) + mr_w[i];
      if ((&m_w[i][MW-1:COORD_W-1]) || !(|m_w[i][MW-1:COORD_W-1])) begin
        ms_w[i] = m_w[i][COORD_W-1:0];
      end else if (m_w[i][MW-1]) begin
        ms_w[i] = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        ms_w[i] = {1'b0, {(COORD_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fadv) begin
      ent_r.meta.pin <= pin4_r;
      ent_r.meta.qin <= qin4_r;
      ent_r.meta.wv  <= wv4_r;
      ent_r.meta.nd  <= nd4_r;
      ent_r.go       <= go4_r;
      ent_r.anum     <= anum4_r;
      ent_r.aden     <= aden4_r;
      ent_r.len2     <= len2_4_r;
      for (int i = 0; i < 3; i++) begin
        ent_r.meta.mirror[i] <= qin4_r ? ms_w[i] : q4_r[i];
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/sibg_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sibg_queue: short item queue between front and back
// Register queue with wrap-bit pointers; push and pop in the same cycle.
// ----------------------------------------------------------------------------
module sibg_queue
  import sibg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  q_ent_t    push_data,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output q_ent_t    pop_data
);

  logic [QPTR_W:0] wp_r, rp_r;
  q_ent_t          mem_r [QUEUE_DEPTH];
  logic            full_w, empty_w;

  assign empty_w    = (wp_r == rp_r);
  assign full_w     = (wp_r[QPTR_W] != rp_r[QPTR_W]) &&
                      (wp_r[QPTR_W-1:0] == rp_r[QPTR_W-1:0]);
  assign push_ready = !full_w;
  assign pop_valid  = !empty_w;
  assign pop_data   = mem_r[rp_r[QPTR_W-1:0]];

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (push_valid && !full_w) wp_r <= wp_r + 1'b1;
      if (pop_ready && !empty_w) rp_r <= rp_r + 1'b1;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push_valid && !full_w) begin
      mem_r[wp_r[QPTR_W-1:0]] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- sv/sibg_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sibg_back: wall distance pipeline
// Square root one bit per stage, product of |num| and length in two stages,
// overflow check, then restoring division one quotient bit per stage.
// ----------------------------------------------------------------------------
module sibg_back
  import sibg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic pop_valid,
  output logic      pop_ready,
  input  q_ent_t    pop_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_item
);

  typedef struct packed {
    meta_t            meta;
    logic             go;
    logic [ABS_W-1:0] aden;
  } bk_carry_t;

  logic badv;
  logic out_valid_r;
  out_item_t out_r;

  // Move the whole back pipeline when the output register is free
  assign badv      = !out_valid_r || out_ready;
  assign pop_ready = badv;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // ---------------- square root stages
  logic             sv_r    [ROOT_W+1];
  bk_carry_t        sc_r    [ROOT_W+1];
  logic [ABS_W-1:0] snum_r  [ROOT_W+1];
  logic [SQ_W-1:0]  srad_r  [ROOT_W+1];
  logic [ROOT_W-1:0] sroot_r [ROOT_W+1];
  logic [RREM_W-1:0] srem_r [ROOT_W+1];

  // Load from the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else if (badv) begin
      sv_r[0] <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (badv) begin
      sc_r[0].meta  <= pop_data.meta;
      sc_r[0].go    <= pop_data.go;
      sc_r[0].aden  <= pop_data.aden;
      snum_r[0]     <= pop_data.anum;
      srad_r[0]     <= pop_data.len2;
      sroot_r[0]    <= '0;
      srem_r[0]     <= '0;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [RREM_W-1:0] cur_w, trl_w;
    logic              ge_w;

    // Bring down two radicand bits, try root*4+1
    assign cur_w = {srem_r[k][RREM_W-3:0], srad_r[k][SQ_W-1 -: 2]};
    assign trl_w = RREM_W'({sroot_r[k], 2'b01});
    assign ge_w  = (cur_w >= trl_w);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k+1] <= 1'b0;
      end else if (badv) begin
        sv_r[k+1] <= sv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (badv) begin
        sc_r[k+1]    <= sc_r[k];
        snum_r[k+1]  <= snum_r[k];
        srad_r[k+1]  <= srad_r[k] << 2;
        sroot_r[k+1] <= {sroot_r[k][ROOT_W-2:0], ge_w};
        srem_r[k+1]  <= ge_w ? (cur_w - trl_w) : cur_w;
      end
    end
  end

  // ---------------- product |num| * length
  logic                       m1v_r, m2v_r;
  bk_carry_t                  m1c_r, m2c_r;
  logic [MSPLIT+ROOT_W-1:0]   mlo_r;
  logic [ABS_W-MSPLIT+ROOT_W-1:0] mhi_r;
  logic [NUMP_W-1:0]          m2n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1v_r <= 1'b0;
      m2v_r <= 1'b0;
    end else if (badv) begin
      m1v_r <= sv_r[ROOT_W];
      m2v_r <= m1v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (badv) begin
      m1c_r <= sc_r[ROOT_W];
      mlo_r <= (MSPLIT+ROOT_W)'(snum_r[ROOT_W][MSPLIT-1:0]) *
               (MSPLIT+ROOT_W)'(sroot_r[ROOT_W]);
      mhi_r <= (ABS_W-MSPLIT+ROOT_W)'(snum_r[ROOT_W][ABS_W-1:MSPLIT]) *
               (ABS_W-MSPLIT+ROOT_W)'(sroot_r[ROOT_W]);
      m2c_r <= m1c_r;
      m2n_r <= (NUMP_W'(mhi_r) << MSPLIT) + NUMP_W'(mlo_r);
    end
  end

  // ---------------- overflow check and division stages
  logic              dv_r   [DIST_W+1];
  bk_carry_t         dc_r   [DIST_W+1];
  logic              dbig_r [DIST_W+1];
  logic [NUMP_W-1:0] drem_r [DIST_W+1];
  logic [DIST_W-1:0] dquo_r [DIST_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (badv) begin
      dv_r[0] <= m2v_r;
    end
  end

  // Flag quotients of 2^31 or more
  always_ff @(posedge clk) begin
    if (badv) begin
      dc_r[0]   <= m2c_r;
      dbig_r[0] <= (m2n_r >= (NUMP_W'(m2c_r.aden) << DIST_W));
      drem_r[0] <= m2n_r;
      dquo_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < DIST_W; j++) begin : g_div
    logic [NUMP_W-1:0] dsub_w;
    logic              ge_w;

    assign dsub_w = NUMP_W'(dc_r[j].aden) << (DIST_W - 1 - j);
    assign ge_w   = (drem_r[j] >= dsub_w);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1] <= 1'b0;
      end else if (badv) begin
        dv_r[j+1] <= dv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (badv) begin
        dc_r[j+1]   <= dc_r[j];
        dbig_r[j+1] <= dbig_r[j];
        drem_r[j+1] <= ge_w ? (drem_r[j] - dsub_w) : drem_r[j];
        dquo_r[j+1] <= {dquo_r[j][DIST_W-2:0], ge_w};
      end
    end
  end

  // ---------------- output register
  logic [DIST_W-1:0] wd_w;
  bk_carry_t         fin_w;

  assign fin_w = dc_r[DIST_W];

  always_comb begin
    if (!fin_w.go) begin
      wd_w = '0;
    end else if (dbig_r[DIST_W]) begin
      wd_w = '1;
    end else begin
      wd_w = dquo_r[DIST_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (badv) begin
      out_valid_r <= dv_r[DIST_W];
    end
  end

  always_ff @(posedge clk) begin
    if (badv) begin
      out_r.p_inside     <= fin_w.meta.pin;
      out_r.q_inside     <= fin_w.meta.qin;
      out_r.wall_valid   <= fin_w.meta.wv;
      out_r.wall_dist    <= wd_w;
      out_r.normal_valid <= fin_w.meta.qin;
      out_r.normal_dist  <= fin_w.meta.nd;
      out_r.mirror_x     <= fin_w.meta.mirror[0];
      out_r.mirror_y     <= fin_w.meta.mirror[1];
      out_r.mirror_z     <= fin_w.meta.mirror[2];
    end
  end

endmodule
`default_nettype wire

// ----- sv/slab_immersed_boundary_geometry_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slab_immersed_boundary_geometry_unit: slab inside test, wall distance, mirror
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_item_t  (P and Q)
//   out_     output     out_valid / out_ready  out_item_t (flags, distances)
//   cfg_     input      cfg_we                 cfg_idx, cfg_data
//
// One item per cycle sustained while out_ready is not held low; the back part holds
// the 33-stage square root and the 31-stage quotient pipeline.
// Synchronous active-low reset clears valid flags, queue pointers and configuration registers.
// Output stalls freeze the back part only; the front keeps taking items until
// its four-entry queue fills, then drops in_ready.
// ----------------------------------------------------------------------------
module slab_immersed_boundary_geometry_unit
  import sibg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  in_item_t                   in_item,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_item,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg;
  logic   push_valid, push_ready, pop_valid, pop_ready;
  q_ent_t push_data, pop_data;

  sibg_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  sibg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sibg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  sibg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

`ifndef SYNTH
  // Front stalls only behind a full queue
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (push_valid && !push_ready))
    else $error("front stalled without a full queue");

  // Wall distance only for an outside P and an inside Q
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.wall_valid) |-> (out_item.q_inside && !out_item.p_inside))
    else $error("wall flag disagrees with inside flags");

  // Invalid distances read as zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_item.wall_valid || out_item.wall_dist == '0) &&
                   (out_item.normal_valid || out_item.normal_dist == '0)))
    else $error("distance set while flagged invalid");
`endif

endmodule
`default_nettype wire
